// ----- design/assert_macros.svh -----
// assertion macros shared by the look-at view matrix rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LAV_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("lav check failed");
`define LAV_ASSERT_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("lav check failed");
`else
`define LAV_ASSERT(lbl, ck, rn, prop)
`define LAV_ASSERT_NR(lbl, ck, prop)
`endif
`endif

// ----- design/lav_pkg.sv -----
// constants and result type for the look-at view matrix pipeline
// no dependencies; used by lav_vnorm, lav_post and look_at_view_matrix
`default_nettype none
package lav_pkg;
  localparam int COORD_WIDTH = 16;
  // normaliser arithmetic
  localparam int NW      = 24;            // magnitude width after scaling
  localparam int SQ_PAD  = 12;            // sum of squares times 4096
  localparam int SUM_W   = 2 * NW + 2;
  localparam int XW      = SUM_W + SQ_PAD;
  localparam int ROOT_W  = XW / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int FRAC_SH = 20;
  localparam int N_W     = NW + FRAC_SH + 1;
  localparam int Q_W     = 15;
  localparam int DR_W    = ROOT_W + 1;
  // fixed point limits
  localparam int UNIT       = 16384;
  localparam int RND_HALF   = 8192;
  localparam int RND_SH     = 14;
  localparam int SH_MAX     = 131071;
  localparam int SH_NEG_LIM = 131072;
  localparam int OUT_W      = 198;
  localparam int OUT_TW     = 200;

  // first member sits in the top bits, so side_x ends up lowest
  typedef struct packed {
    logic signed [17:0] shift_z;
    logic signed [17:0] shift_y;
    logic signed [17:0] shift_x;
    logic signed [15:0] back_z;
    logic signed [15:0] back_y;
    logic signed [15:0] back_x;
    logic signed [15:0] upward_z;
    logic signed [15:0] upward_y;
    logic signed [15:0] upward_x;
    logic signed [15:0] side_z;
    logic signed [15:0] side_y;
    logic signed [15:0] side_x;
  } res_t;
endpackage
`default_nettype wire

// ----- design/lav_vnorm.sv -----
// pipelined vector normaliser: scale, sum of squares, bitwise square root
// and three restoring dividers; depends on lav_pkg
`default_nettype none
module lav_vnorm #(
  parameter int VW = 17,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [3*VW-1:0] in_vec,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [47:0]     out_vec,
  output logic            out_zero,
  output logic [SW-1:0]   out_side
);
  localparam int NW     = lav_pkg::NW;
  localparam int MXW    = (VW > NW) ? VW : NW;
  localparam int PW     = $clog2(MXW + 1);
  localparam int SUM_W  = lav_pkg::SUM_W;
  localparam int XW     = lav_pkg::XW;
  localparam int ROOT_W = lav_pkg::ROOT_W;
  localparam int REM_W  = lav_pkg::REM_W;
  localparam int N_W    = lav_pkg::N_W;
  localparam int Q_W    = lav_pkg::Q_W;
  localparam int DR_W   = lav_pkg::DR_W;

  typedef struct packed {
    logic [2:0]    neg;
    logic          nz;
    logic [SW-1:0] side;
  } meta_t;

  // stage a: magnitudes
  logic          va_r;
  logic [VW-1:0] ma_r [3];
  meta_t         meta_a_r;
  logic [VW-1:0] mag_c [3];
  logic [2:0]    neg_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = in_vec[i*VW + VW - 1];
      mag_c[i] = neg_c[i] ? (~in_vec[i*VW +: VW] + VW'(1)) : in_vec[i*VW +: VW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      ma_r     <= mag_c;
      meta_a_r <= '{neg: neg_c, nz: |in_vec, side: in_side};
    end
  end

  // stage b: largest magnitude
  logic          vb_r;
  logic [VW-1:0] mb_r [3];
  logic [VW-1:0] mxb_r;
  meta_t         meta_b_r;
  logic [VW-1:0] mx01_c;

  assign mx01_c = (ma_r[0] > ma_r[1]) ? ma_r[0] : ma_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
    if (en) begin
      mb_r     <= ma_r;
      mxb_r    <= (ma_r[2] > mx01_c) ? ma_r[2] : mx01_c;
      meta_b_r <= meta_a_r;
    end
  end

  // stage c: scaling shift from the leading one
  logic          vc_r;
  logic [VW-1:0] mc_r [3];
  logic [PW-1:0] shc_r;
  meta_t         meta_c_r;
  logic [PW-1:0] msb_c;
  logic [MXW-1:0] mxw_c;

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < VW; b++) begin
      if (mxb_r[b]) msb_c = PW'(b);
    end
    mxw_c = MXW'(mxb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
    if (en) begin
      mc_r     <= mb_r;
      shc_r    <= (|(mxw_c >> NW)) ? (msb_c - PW'(NW - 1)) : '0;
      meta_c_r <= meta_b_r;
    end
  end

  // stage d: scaled magnitudes, truncated toward zero
  logic          vd_r;
  logic [NW-1:0] md_r [3];
  meta_t         meta_d_r;
  logic [MXW-1:0] shm_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) shm_c[i] = MXW'(mc_r[i]) >> shc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) md_r[i] <= shm_c[i][NW-1:0];
      meta_d_r <= meta_c_r;
    end
  end

  // stage e: squares
  logic            ve_r;
  logic [2*NW-1:0] sqe_r [3];
  logic [NW-1:0]   me_r [3];
  meta_t           meta_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) sqe_r[i] <= md_r[i] * md_r[i];
      me_r     <= md_r;
      meta_e_r <= meta_d_r;
    end
  end

  // stage f: sum of squares
  logic             vf_r;
  logic [SUM_W-1:0] sumf_r;
  logic [NW-1:0]    mf_r [3];
  meta_t            metaf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
    if (en) begin
      sumf_r  <= SUM_W'(sqe_r[0]) + SUM_W'(sqe_r[1]) + SUM_W'(sqe_r[2]);
      mf_r    <= me_r;
      metaf_r <= meta_e_r;
    end
  end

  // square root, one result bit per stage
  logic              rv_r    [ROOT_W];
  logic [REM_W-1:0]  rrem_r  [ROOT_W];
  logic [ROOT_W-1:0] rroot_r [ROOT_W];
  logic [SUM_W-1:0]  rx_r    [ROOT_W];
  logic [NW-1:0]     rm_r    [ROOT_W][3];
  meta_t             rmeta_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_rt
    logic              v_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SUM_W-1:0]  x_i;
    logic [NW-1:0]     m_i [3];
    meta_t             meta_i;
    logic [XW-1:0]     xx;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign v_i    = vf_r;
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = sumf_r;
      assign m_i    = mf_r;
      assign meta_i = metaf_r;
    end else begin : g_next
      assign v_i    = rv_r[k-1];
      assign rem_i  = rrem_r[k-1];
      assign root_i = rroot_r[k-1];
      assign x_i    = rx_r[k-1];
      assign m_i    = rm_r[k-1];
      assign meta_i = rmeta_r[k-1];
    end

    assign xx    = {x_i, {lav_pkg::SQ_PAD{1'b0}}};
    assign t     = {rem_i, xx[XW-1-2*k -: 2]};
    assign trial = {2'b00, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k] <= 1'b0;
      end else if (en) begin
        rv_r[k] <= v_i;
      end
      if (en) begin
        rx_r[k]    <= x_i;
        rm_r[k]    <= m_i;
        rmeta_r[k] <= meta_i;
        if (t >= trial) begin
          rrem_r[k]  <= REM_W'(t - trial);
          rroot_r[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rrem_r[k]  <= t[REM_W-1:0];
          rroot_r[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // stage g: rounded dividends
  logic              vg_r;
  logic [ROOT_W-1:0] lg_r;
  logic [DR_W-1:0]   rg_r [3];
  logic [Q_W-1:0]    ng_r [3];
  meta_t             metag_r;
  logic [N_W-1:0]    num_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = N_W'({rm_r[ROOT_W-1][i], {lav_pkg::FRAC_SH{1'b0}}})
               + N_W'(rroot_r[ROOT_W-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= rv_r[ROOT_W-1];
    end
    if (en) begin
      lg_r <= rroot_r[ROOT_W-1];
      for (int i = 0; i < 3; i++) begin
        rg_r[i] <= DR_W'(num_c[i][N_W-1:Q_W]);
        ng_r[i] <= num_c[i][Q_W-1:0];
      end
      metag_r <= rmeta_r[ROOT_W-1];
    end
  end

  // restoring division, one quotient bit per stage
  logic              dv_r    [Q_W];
  logic [ROOT_W-1:0] dl_r    [Q_W];
  logic [DR_W-1:0]   dr_r    [Q_W][3];
  logic [Q_W-1:0]    dq_r    [Q_W][3];
  logic [Q_W-1:0]    dn_r    [Q_W][3];
  meta_t             dmeta_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_dv
    logic              v_i;
    logic [ROOT_W-1:0] l_i;
    logic [DR_W-1:0]   r_i [3];
    logic [Q_W-1:0]    q_i [3];
    logic [Q_W-1:0]    n_i [3];
    meta_t             meta_i;
    logic [DR_W:0]     t [3];
    logic [DR_W:0]     lz;

    if (j == 0) begin : g_first
      assign v_i    = vg_r;
      assign l_i    = lg_r;
      assign r_i    = rg_r;
      assign q_i    = '{default: '0};
      assign n_i    = ng_r;
      assign meta_i = metag_r;
    end else begin : g_next
      assign v_i    = dv_r[j-1];
      assign l_i    = dl_r[j-1];
      assign r_i    = dr_r[j-1];
      assign q_i    = dq_r[j-1];
      assign n_i    = dn_r[j-1];
      assign meta_i = dmeta_r[j-1];
    end

    assign lz = (DR_W + 1)'(l_i);

    always_comb begin
      for (int i = 0; i < 3; i++) t[i] = {r_i[i], n_i[i][Q_W-1-j]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= v_i;
      end
      if (en) begin
        dl_r[j]    <= l_i;
        dn_r[j]    <= n_i;
        dmeta_r[j] <= meta_i;
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= lz) begin
            dr_r[j][i] <= DR_W'(t[i] - lz);
            dq_r[j][i] <= {q_i[i][Q_W-2:0], 1'b1};
          end else begin
            dr_r[j][i] <= t[i][DR_W-1:0];
            dq_r[j][i] <= {q_i[i][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // stage h: clamp to one and restore sign
  logic           vh_r;
  logic [47:0]    vech_r;
  logic           zh_r;
  logic [SW-1:0]  sideh_r;
  logic [Q_W-1:0] qc_c [3];
  logic [47:0]    vec_c;
  meta_t          mlast;

  assign mlast = dmeta_r[Q_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc_c[i] = (dq_r[Q_W-1][i] > Q_W'(lav_pkg::UNIT)) ? Q_W'(lav_pkg::UNIT)
                                                       : dq_r[Q_W-1][i];
      if (!mlast.nz) begin
        vec_c[16*i +: 16] = '0;
      end else if (mlast.neg[i]) begin
        vec_c[16*i +: 16] = 16'd0 - {1'b0, qc_c[i]};
      end else begin
        vec_c[16*i +: 16] = {1'b0, qc_c[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (en) begin
      vh_r <= dv_r[Q_W-1];
    end
    if (en) begin
      vech_r  <= vec_c;
      zh_r    <= !mlast.nz;
      sideh_r <= mlast.side;
    end
  end

  assign out_valid = vh_r;
  assign out_vec   = vech_r;
  assign out_zero  = zh_r;
  assign out_side  = sideh_r;
endmodule
`default_nettype wire

// ----- design/lav_post.sv -----
// recomputed up row, back row and saturated translation column
// depends on lav_pkg
`default_nettype none
module lav_post #(
  parameter int CW = lav_pkg::COORD_WIDTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [47:0]     in_side,
  input  logic [47:0]     in_fwd,
  input  logic            in_zero,
  input  logic [3*CW-1:0] in_eye,
  output logic            out_valid,
  output lav_pkg::res_t   out_res
);
  localparam int PE_W = CW + 16;
  localparam int DW   = CW + 18;

  function automatic logic signed [15:0] rnd_unit(input logic signed [32:0] d);
    logic [32:0] mg;
    logic [33:0] m;
    logic [14:0] mc;
    mg = d[32] ? (~$unsigned(d) + 33'd1) : $unsigned(d);
    m  = ({1'b0, mg} + 34'(lav_pkg::RND_HALF)) >> lav_pkg::RND_SH;
    mc = (m > 34'(lav_pkg::UNIT)) ? 15'(lav_pkg::UNIT) : m[14:0];
    return d[32] ? (16'd0 - {1'b0, mc}) : {1'b0, mc};
  endfunction

  // rounds by 14, negates and saturates to 18 bits
  function automatic logic [17:0] rnd_shift(input logic signed [DW-1:0] d);
    logic [DW-1:0] mg;
    logic [DW:0]   m;
    logic [17:0]   r;
    mg = d[DW-1] ? (~$unsigned(d) + DW'(1)) : $unsigned(d);
    m  = ({1'b0, mg} + (DW + 1)'(lav_pkg::RND_HALF)) >> lav_pkg::RND_SH;
    if (d[DW-1]) begin
      r = (m > (DW + 1)'(lav_pkg::SH_MAX)) ? 18'(lav_pkg::SH_MAX) : m[17:0];
    end else begin
      r = (m > (DW + 1)'(lav_pkg::SH_NEG_LIM)) ? (18'd0 - 18'(lav_pkg::SH_NEG_LIM))
                                               : (18'd0 - m[17:0]);
    end
    return r;
  endfunction

  logic signed [15:0]   s_c [3];
  logic signed [15:0]   f_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_c[i] = $signed(in_side[16*i +: 16]);
      f_c[i] = $signed(in_fwd[16*i +: 16]);
    end
  end

  // q1: products for u = s x f, back row
  logic                 v1_r, z1_r;
  logic signed [31:0]   p1_r [6];
  logic signed [15:0]   s1_r [3];
  logic signed [15:0]   b1_r [3];
  logic [3*CW-1:0]      e1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      p1_r[0] <= s_c[1] * f_c[2];
      p1_r[1] <= s_c[2] * f_c[1];
      p1_r[2] <= s_c[2] * f_c[0];
      p1_r[3] <= s_c[0] * f_c[2];
      p1_r[4] <= s_c[0] * f_c[1];
      p1_r[5] <= s_c[1] * f_c[0];
      for (int i = 0; i < 3; i++) b1_r[i] <= 16'sd0 - f_c[i];
      s1_r <= s_c;
      e1_r <= in_eye;
      z1_r <= in_zero;
    end
  end

  // q2: differences
  logic                 v2_r, z2_r;
  logic signed [32:0]   d2_r [3];
  logic signed [15:0]   s2_r [3];
  logic signed [15:0]   b2_r [3];
  logic [3*CW-1:0]      e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d2_r[i] <= $signed({p1_r[2*i][31], p1_r[2*i]})
                 - $signed({p1_r[2*i+1][31], p1_r[2*i+1]});
      end
      s2_r <= s1_r;
      b2_r <= b1_r;
      e2_r <= e1_r;
      z2_r <= z1_r;
    end
  end

  // q3: round and clamp u
  logic                 v3_r, z3_r;
  logic signed [15:0]   u3_r [3];
  logic signed [15:0]   s3_r [3];
  logic signed [15:0]   b3_r [3];
  logic [3*CW-1:0]      e3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) u3_r[i] <= rnd_unit(d2_r[i]);
      s3_r <= s2_r;
      b3_r <= b2_r;
      e3_r <= e2_r;
      z3_r <= z2_r;
    end
  end

  // q4: row times eye products
  logic                 v4_r, z4_r;
  logic signed [PE_W-1:0] p4_r [9];
  logic signed [15:0]   s4_r [3];
  logic signed [15:0]   u4_r [3];
  logic signed [15:0]   b4_r [3];
  logic signed [CW-1:0] eye_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) eye_c[i] = $signed(e3_r[CW*i +: CW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_r[i]     <= s3_r[i] * eye_c[i];
        p4_r[3 + i] <= u3_r[i] * eye_c[i];
        p4_r[6 + i] <= b3_r[i] * eye_c[i];
      end
      s4_r <= s3_r;
      u4_r <= u3_r;
      b4_r <= b3_r;
      z4_r <= z3_r;
    end
  end

  // q5: dot products
  logic                 v5_r, z5_r;
  logic signed [DW-1:0] dot5_r [3];
  logic signed [15:0]   s5_r [3];
  logic signed [15:0]   u5_r [3];
  logic signed [15:0]   b5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        dot5_r[r] <= $signed({{2{p4_r[3*r][PE_W-1]}}, p4_r[3*r]})
                   + $signed({{2{p4_r[3*r+1][PE_W-1]}}, p4_r[3*r+1]})
                   + $signed({{2{p4_r[3*r+2][PE_W-1]}}, p4_r[3*r+2]});
      end
      s5_r <= s4_r;
      u5_r <= u4_r;
      b5_r <= b4_r;
      z5_r <= z4_r;
    end
  end

  // q6: translation, zero forcing
  logic          v6_r;
  lav_pkg::res_t res6_r;
  lav_pkg::res_t res_c;

  always_comb begin
    res_c.side_x   = s5_r[0];
    res_c.side_y   = s5_r[1];
    res_c.side_z   = s5_r[2];
    res_c.upward_x = u5_r[0];
    res_c.upward_y = u5_r[1];
    res_c.upward_z = u5_r[2];
    res_c.back_x   = b5_r[0];
    res_c.back_y   = b5_r[1];
    res_c.back_z   = b5_r[2];
    res_c.shift_x  = rnd_shift(dot5_r[0]);
    res_c.shift_y  = rnd_shift(dot5_r[1]);
    res_c.shift_z  = rnd_shift(dot5_r[2]);
    if (z5_r) res_c = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
    if (en) begin
      res6_r <= res_c;
    end
  end

  assign out_valid = v6_r;
  assign out_res   = res6_r;
endmodule
`default_nettype wire

// ----- design/look_at_view_matrix.sv -----
// top level of the look-at view matrix pipeline: front subtract, cross
// product, output skid buffer; depends on lav_pkg, lav_vnorm, lav_post
//
// channel  dir  handshake          word
// in_      in   in_tvalid/tready   eye xyz, target xyz, up xyz, COORD_WIDTH each
// out_     out  out_tvalid/tready  side, upward, back rows, shift column
//
// one word accepted per clock while the output skid has room; a full skid stalls the pipeline
// depth set by the two normalisers: 31-stage square root, 15-stage divider
// single pipeline enable; a two-entry skid at the output absorbs a stall
// so the input keeps going after out_tready drops until the spare entry fills
// reset clears all valid bits; payload registers are not reset
`default_nettype none
`include "assert_macros.svh"
module look_at_view_matrix #(
  parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // side_x/y/z, upward_x/y/z, back_x/y/z (16 each), shift_x/y/z (18 each)
  output logic [lav_pkg::OUT_TW-1:0] out_tdata
);
  localparam int CW   = COORD_WIDTH;
  localparam int FW   = CW + 1;          // forward difference width
  localparam int SVW  = CW + 17;         // unnormalised side width
  localparam int FSW  = 6 * CW;          // sideband through forward normaliser
  localparam int SSW  = 3 * CW + 49;     // sideband through side normaliser

  logic en;

  // input register: forward difference
  logic          iv_r;
  logic [3*CW-1:0] ie_r, iu_r;
  logic [3*FW-1:0] if_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (en) begin
      iv_r <= in_tvalid;
    end
    if (en) begin
      ie_r <= in_tdata[3*CW-1:0];
      iu_r <= in_tdata[9*CW-1:6*CW];
      for (int i = 0; i < 3; i++) begin
        if_r[FW*i +: FW] <= $signed({in_tdata[CW*(3+i) + CW - 1], in_tdata[CW*(3+i) +: CW]})
                          - $signed({in_tdata[CW*i + CW - 1], in_tdata[CW*i +: CW]});
      end
    end
  end

  // normalise forward
  logic           fn_v, fn_z;
  logic [47:0]    fn_vec;
  logic [FSW-1:0] fn_side;

  lav_vnorm #(.VW(FW), .SW(FSW)) u_fnorm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (iv_r),
    .in_vec   (if_r),
    .in_side  ({iu_r, ie_r}),
    .out_valid(fn_v),
    .out_vec  (fn_vec),
    .out_zero (fn_z),
    .out_side (fn_side)
  );

  // side = normalised forward x up, products then differences
  logic signed [15:0] nf_c [3];
  logic signed [CW-1:0] up_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nf_c[i] = $signed(fn_vec[16*i +: 16]);
      up_c[i] = $signed(fn_side[3*CW + CW*i +: CW]);
    end
  end

  logic                 x1v_r, x1fz_r;
  logic signed [CW+15:0] x1p_r [6];
  logic [3*CW-1:0]      x1e_r;
  logic [47:0]          x1f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1v_r <= 1'b0;
    end else if (en) begin
      x1v_r <= fn_v;
    end
    if (en) begin
      x1p_r[0] <= nf_c[1] * up_c[2];
      x1p_r[1] <= nf_c[2] * up_c[1];
      x1p_r[2] <= nf_c[2] * up_c[0];
      x1p_r[3] <= nf_c[0] * up_c[2];
      x1p_r[4] <= nf_c[0] * up_c[1];
      x1p_r[5] <= nf_c[1] * up_c[0];
      x1e_r    <= fn_side[3*CW-1:0];
      x1f_r    <= fn_vec;
      x1fz_r   <= fn_z;
    end
  end

  logic            x2v_r, x2fz_r;
  logic [3*SVW-1:0] x2s_r;
  logic [3*CW-1:0] x2e_r;
  logic [47:0]     x2f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2v_r <= 1'b0;
    end else if (en) begin
      x2v_r <= x1v_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x2s_r[SVW*i +: SVW] <= $signed({x1p_r[2*i][CW+15], x1p_r[2*i]})
                             - $signed({x1p_r[2*i+1][CW+15], x1p_r[2*i+1]});
      end
      x2e_r  <= x1e_r;
      x2f_r  <= x1f_r;
      x2fz_r <= x1fz_r;
    end
  end

  // normalise side
  logic           sn_v, sn_z;
  logic [47:0]    sn_vec;
  logic [SSW-1:0] sn_side;

  lav_vnorm #(.VW(SVW), .SW(SSW)) u_snorm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (x2v_r),
    .in_vec   (x2s_r),
    .in_side  ({x2fz_r, x2f_r, x2e_r}),
    .out_valid(sn_v),
    .out_vec  (sn_vec),
    .out_zero (sn_z),
    .out_side (sn_side)
  );

  // up row, back row, translation
  logic          post_v;
  lav_pkg::res_t post_res;

  lav_post #(.CW(CW)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sn_v),
    .in_side  (sn_vec),
    .in_fwd   (sn_side[3*CW +: 48]),
    .in_zero  (sn_z | sn_side[SSW-1]),
    .in_eye   (sn_side[3*CW-1:0]),
    .out_valid(post_v),
    .out_res  (post_res)
  );

  // output skid: out register plus one spare word
  logic          ovld_r, spare_vld_r;
  lav_pkg::res_t out_r, spare_r;
  logic          push, pop;

  assign en   = !spare_vld_r || !post_v;
  assign push = en && post_v;
  assign pop  = ovld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r      <= 1'b0;
      spare_vld_r <= 1'b0;
    end else if (pop || !ovld_r) begin
      if (spare_vld_r) begin
        ovld_r      <= 1'b1;
        spare_vld_r <= push;
      end else begin
        ovld_r      <= push;
      end
    end else if (push) begin
      spare_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !ovld_r) begin
      if (spare_vld_r) begin
        out_r   <= spare_r;
        spare_r <= post_res;
      end else begin
        out_r   <= post_res;
      end
    end else if (push) begin
      spare_r <= post_res;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {(lav_pkg::OUT_TW - lav_pkg::OUT_W)'(0), out_r};

  `LAV_ASSERT(a_spare_needs_out, clk, rst_n, spare_vld_r |-> ovld_r)
  `LAV_ASSERT(a_spare_held, clk, rst_n, (spare_vld_r && !pop) |=> (spare_vld_r && $stable(spare_r)))
  `LAV_ASSERT(a_side_unit, clk, rst_n, ovld_r |-> (out_r.side_x <= 16'sd16384 && out_r.side_x >= -16'sd16384))
  `LAV_ASSERT_NR(a_reset_empty, clk, !rst_n |=> (!ovld_r && !spare_vld_r))
endmodule
`default_nettype wire

// ----- dv/lav_checker.sv -----
// checker for the look-at view matrix: watches both channels, predicts each result
// depends on lav_pkg; instantiated by tb_look_at_view_matrix beside the block
module lav_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  lav_pkg::res_t view_q[$];

  function automatic longint rnd14(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 8192) >>> 14;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > lav_pkg::UNIT) return lav_pkg::UNIT;
    if (v < -lav_pkg::UNIT) return -lav_pkg::UNIT;
    return v;
  endfunction

  function automatic longint root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale to unit length in q1.14; returns 0 for a zero vector
  function automatic bit unit_vec(ref longint v[3]);
    longint unsigned m[3], mx, s, len, q;
    int sh;
    mx = 0;
    s = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while ((mx >> sh) >= (64'd1 << 24)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> sh;
      s += m[i] * m[i];
    end
    len = root64(s << 12);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 20) + len / 2) / len;
      if (q > lav_pkg::UNIT) q = lav_pkg::UNIT;
      v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic logic [17:0] shift_term(longint r[3], longint e[3]);
    longint t;
    t = -rnd14(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
    if (t > lav_pkg::SH_MAX) t = lav_pkg::SH_MAX;
    if (t < -lav_pkg::SH_NEG_LIM) t = -lav_pkg::SH_NEG_LIM;
    return t[17:0];
  endfunction

  function automatic lav_pkg::res_t view_of(logic [143:0] w);
    longint eye[3], up[3], f[3], s[3], u[3], b[3];
    lav_pkg::res_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(w[16*i +: 16]));
      f[i] = longint'($signed(w[16*(3+i) +: 16])) - eye[i];
      up[i] = longint'($signed(w[16*(6+i) +: 16]));
    end
    if (!unit_vec(f)) return r;
    s[0] = f[1] * up[2] - f[2] * up[1];
    s[1] = f[2] * up[0] - f[0] * up[2];
    s[2] = f[0] * up[1] - f[1] * up[0];
    if (!unit_vec(s)) return r;
    u[0] = clamp_unit(rnd14(s[1] * f[2] - s[2] * f[1]));
    u[1] = clamp_unit(rnd14(s[2] * f[0] - s[0] * f[2]));
    u[2] = clamp_unit(rnd14(s[0] * f[1] - s[1] * f[0]));
    for (int i = 0; i < 3; i++) b[i] = -f[i];
    r.side_x = 16'(s[0]); r.side_y = 16'(s[1]); r.side_z = 16'(s[2]);
    r.upward_x = 16'(u[0]); r.upward_y = 16'(u[1]); r.upward_z = 16'(u[2]);
    r.back_x = 16'(b[0]); r.back_y = 16'(b[1]); r.back_z = 16'(b[2]);
    r.shift_x = shift_term(s, eye);
    r.shift_y = shift_term(u, eye);
    r.shift_z = shift_term(b, eye);
    return r;
  endfunction

  task automatic cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    lav_pkg::res_t e, a;
    if (rst_n && in_tvalid && in_tready) view_q.push_back(view_of(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      a = out_tdata[197:0];
      if (view_q.size() == 0) begin
        $error("result with no matching input");
        fail_count++;
      end else begin
        e = view_q.pop_front();
        cmp("side_x", e.side_x, a.side_x);
        cmp("side_y", e.side_y, a.side_y);
        cmp("side_z", e.side_z, a.side_z);
        cmp("upward_x", e.upward_x, a.upward_x);
        cmp("upward_y", e.upward_y, a.upward_y);
        cmp("upward_z", e.upward_z, a.upward_z);
        cmp("back_x", e.back_x, a.back_x);
        cmp("back_y", e.back_y, a.back_y);
        cmp("back_z", e.back_z, a.back_z);
        cmp("shift_x", e.shift_x, a.shift_x);
        cmp("shift_y", e.shift_y, a.shift_y);
        cmp("shift_z", e.shift_z, a.shift_z);
      end
    end
    pending = view_q.size();
  end
endmodule

// ----- dv/tb_look_at_view_matrix.sv -----
// stimulus and verdict for the look-at view matrix pipeline
// depends on lav_pkg, look_at_view_matrix and lav_checker
module tb_look_at_view_matrix;
  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  // side_x/y/z, upward_x/y/z, back_x/y/z, shift_x/y/z
  logic [199:0] out_tdata;
  int           fail_count, pending;
  int           idle_cycles = 0;
  bit           calm = 0;       // last part of the run: no idling either side
  bit           hold_done = 0;  // long receiver stall already done
  bit           feeding = 1;

  localparam int N_RAND  = 1300;
  localparam int LATENCY = 118;
  localparam int WATCHDOG = 5000;

  always #5 clk = ~clk;

  look_at_view_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  lav_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // directed words: extremes and the degenerate cases
  logic [143:0] corner_q[$];

  function automatic logic [143:0] pack9(int v[9]);
    logic [143:0] w;
    for (int i = 0; i < 9; i++) w[16*i +: 16] = 16'(v[i]);
    return w;
  endfunction

  // well-formed camera set-ups half the time; otherwise up parallel to forward, eye on target, extreme eye or raw noise
  function automatic logic [143:0] random_word();
    int v[9];
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = $signed(16'($urandom));
    if (k < 5) begin
      for (int i = 0; i < 9; i++) v[i] = $signed(16'($urandom_range(0, 4095))) - 2048;
    end else if (k == 5) begin
      // up parallel to forward
      for (int i = 0; i < 3; i++) begin
        v[i] = $signed(16'($urandom_range(0, 1023))) - 512;
        v[3+i] = v[i] + ($signed(16'($urandom_range(0, 255))) - 128);
        v[6+i] = (v[3+i] - v[i]) * 2;
      end
    end else if (k == 6) begin
      for (int i = 0; i < 3; i++) v[3+i] = v[i];
    end else if (k == 7) begin
      for (int i = 0; i < 3; i++) v[i] = ($urandom_range(0, 1)) ? 32767 : -32768;
    end
    return pack9(v);
  endfunction

  initial begin
    int v[9];
    v = '{0, 0, 0, 0, 0, -256, 0, 256, 0};           corner_q.push_back(pack9(v));
    v = '{256, 512, 768, 256, 512, 768, 0, 256, 0};  corner_q.push_back(pack9(v));
    v = '{0, 0, 0, 256, 0, 0, 0, 0, 0};              corner_q.push_back(pack9(v));
    v = '{0, 0, 0, 256, 0, 0, 512, 0, 0};            corner_q.push_back(pack9(v));
    v = '{0, 0, 0, 256, 0, 0, -512, 0, 0};           corner_q.push_back(pack9(v));
    v = '{-32768, -32768, -32768, 32767, 32767, 32767, 0, 256, 0};
    corner_q.push_back(pack9(v));
    v = '{32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, -32768};
    corner_q.push_back(pack9(v));
    v = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767};
    corner_q.push_back(pack9(v));
    v = '{-32768, 32767, 0, 32767, -32768, 1, 1, 1, -1};
    corner_q.push_back(pack9(v));
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                corner_q.push_back(pack9(v));
    v = '{-1, -1, -1, 0, 0, 0, -1, -1, -1};          corner_q.push_back(pack9(v));
    v = '{32767, 0, 0, 32767, 0, 256, 32767, -32768, 0};
    corner_q.push_back(pack9(v));
  end

  // sender: bursts of idling, then none in the last stretch
  initial begin
    int gap;
    int sent;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    sent = 0;
    while (sent < corner_q.size() + N_RAND) begin
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1;
      in_tdata <= (sent < corner_q.size()) ? corner_q[sent] : random_word();
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sent++;
      if (sent > corner_q.size() + N_RAND - 200) calm = 1;
    end
    in_tvalid <= 0;
    feeding = 0;
  end

  // receiver: random stalls, one long hold-off to fill the pipe
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && chk.pending > 40) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_done = 1;
      end
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_look_at_view_matrix: errors");
      $finish;
    end
  end

  // verdict once all words are in and the pipe has drained
  initial begin
    wait (rst_n);
    wait (!feeding);
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_look_at_view_matrix: clean");
    end else begin
      $display("tb_look_at_view_matrix: errors");
    end
    $finish;
  end
endmodule
